FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expr holds in the cycle after cond, outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

// Checks that expr holds in the same cycle as cond, outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

`endif

FILE: hw/rtl/wmlf_pkg.sv
package wmlf_pkg;

    localparam int LABEL_W      = 8;
    localparam int MASK_W       = 4;
    localparam int LINE_W       = 16;
    localparam int REG_W        = 64;
    localparam int ADDR_W       = 6;
    localparam int COEF_PACKS   = 4;
    localparam int COEF_SLOT_W  = 16;
    localparam int COEF_BITS    = 16;
    localparam int COEF_W       = (COEF_BITS < COEF_SLOT_W) ? COEF_BITS : COEF_SLOT_W;
    localparam int LABELS       = 256;
    localparam int MAX_TAPS_DEF = 15;
    localparam int PEND_W       = 4;

    localparam logic [MASK_W-1:0] MASK_LENGTH_RESET = 4'd5;
    localparam logic [LINE_W-1:0] LINE_LENGTH_RESET = 16'd512;

    typedef enum logic [2:0] {
        REG_MASK_LENGTH = 3'd0,
        REG_LINE_LENGTH = 3'd1,
        REG_COEF_PACK_0 = 3'd2,
        REG_COEF_PACK_1 = 3'd3,
        REG_COEF_PACK_2 = 3'd4,
        REG_COEF_PACK_3 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [MASK_W-1:0]                  taps;
        logic [COEF_PACKS-1:0][REG_W-1:0]   coef;
    } vote_cfg_t;

endpackage

FILE: hw/rtl/wmlf_if.sv
interface wmlf_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [wmlf_pkg::LABEL_W-1:0] pixel_label;

    modport source (output valid, output pixel_label, input ready);
    modport sink (input valid, input pixel_label, output ready);
endinterface

interface wmlf_result_if;
    logic                         valid;
    logic                         ready;
    logic [wmlf_pkg::LABEL_W-1:0] smoothed_label;
    logic                         line_done;

    modport source (output valid, output smoothed_label, output line_done, input ready);
    modport sink (input valid, input smoothed_label, input line_done, output ready);
endinterface

FILE: hw/rtl/weighted_mode_label_filter.sv
// Order: a pixel accepted is written into the window register, and the result that it completes
// is loaded from the vote unit into the output register when that register is free. Throughput:
// one pixel per cycle along the line while results are taken; the last pixel of a line holds
// the input while the vote unit, fed by the window register, emits the trailing results one per
// cycle while results are taken.
// Reset (rst_n, asynchronous, active low) empties the pipeline, restarts the line and
// loads the register defaults; no clearing pass is needed.
module weighted_mode_label_filter #(
    parameter int MAX_TAPS = wmlf_pkg::MAX_TAPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wmlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [wmlf_pkg::REG_W-1:0]    pwdata,
    output logic [wmlf_pkg::REG_W-1:0]    prdata,
    output logic                          pready,
    wmlf_pixel_if.sink                    pixel,
    wmlf_result_if.source                 result
);

    logic [wmlf_pkg::MASK_W-1:0]                         mask_length_reg;
    logic [wmlf_pkg::LINE_W-1:0]                         line_length_reg;
    logic [wmlf_pkg::COEF_PACKS-1:0][wmlf_pkg::REG_W-1:0] coef_reg;

    logic [wmlf_pkg::LABEL_W-1:0] win_reg [MAX_TAPS];
    logic [wmlf_pkg::LABEL_W-1:0] win_next [MAX_TAPS];
    logic [wmlf_pkg::LINE_W-1:0]  pos_reg, pos_next;
    logic [wmlf_pkg::PEND_W-1:0]  pend_reg, pend_next;
    logic                         bypass_reg, bypass_next;
    logic                         last_reg, last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [wmlf_pkg::LABEL_W-1:0] out_label_reg, out_label_next;
    logic                         out_done_reg, out_done_next;

    logic [wmlf_pkg::MASK_W-1:0]  taps;
    logic [wmlf_pkg::MASK_W-1:0]  half;
    logic                         short_line;
    logic                         line_end;
    logic                         issue;
    logic                         in_ready;
    logic                         accept;
    logic                         cfg_wr;
    logic                         restart;
    wmlf_pkg::reg_idx_t           cfg_idx;
    wmlf_pkg::vote_cfg_t          vote_cfg;
    logic [wmlf_pkg::LABEL_W-1:0] vote_label;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = wmlf_pkg::reg_idx_t'(paddr[wmlf_pkg::ADDR_W-1:3]);
    assign restart = cfg_wr && ((cfg_idx == wmlf_pkg::REG_MASK_LENGTH) ||
                                (cfg_idx == wmlf_pkg::REG_LINE_LENGTH));

    always_comb
    begin
        unique case (cfg_idx)
            wmlf_pkg::REG_MASK_LENGTH: prdata = wmlf_pkg::REG_W'(mask_length_reg);
            wmlf_pkg::REG_LINE_LENGTH: prdata = wmlf_pkg::REG_W'(line_length_reg);
            wmlf_pkg::REG_COEF_PACK_0: prdata = coef_reg[0];
            wmlf_pkg::REG_COEF_PACK_1: prdata = coef_reg[1];
            wmlf_pkg::REG_COEF_PACK_2: prdata = coef_reg[2];
            wmlf_pkg::REG_COEF_PACK_3: prdata = coef_reg[3];
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_length_reg <= wmlf_pkg::MASK_LENGTH_RESET;
            line_length_reg <= wmlf_pkg::LINE_LENGTH_RESET;
            coef_reg        <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                wmlf_pkg::REG_MASK_LENGTH:
                    mask_length_reg <= pwdata[wmlf_pkg::MASK_W-1:0];
                wmlf_pkg::REG_LINE_LENGTH:
                    line_length_reg <= pwdata[wmlf_pkg::LINE_W-1:0];
                wmlf_pkg::REG_COEF_PACK_0: coef_reg[0] <= pwdata;
                wmlf_pkg::REG_COEF_PACK_1: coef_reg[1] <= pwdata;
                wmlf_pkg::REG_COEF_PACK_2: coef_reg[2] <= pwdata;
                wmlf_pkg::REG_COEF_PACK_3: coef_reg[3] <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (mask_length_reg == '0)
        begin
            taps = wmlf_pkg::MASK_W'(1);
        end
        else if (int'(mask_length_reg) > MAX_TAPS)
        begin
            taps = wmlf_pkg::MASK_W'(MAX_TAPS);
        end
        else
        begin
            taps = mask_length_reg;
        end
        half       = taps >> 1;
        short_line = (line_length_reg < wmlf_pkg::LINE_W'(2)) ||
                     (line_length_reg < wmlf_pkg::LINE_W'(taps));
        line_end   = (pos_reg >= (line_length_reg - wmlf_pkg::LINE_W'(1)));
    end

    assign vote_cfg.taps = taps;
    assign vote_cfg.coef = coef_reg;

    wmlf_vote #(
        .MAX_TAPS (MAX_TAPS)
    ) u_vote (
        .win   (win_reg),
        .cfg   (vote_cfg),
        .label (vote_label)
    );

    assign issue    = (pend_reg != '0) && (!out_valid_reg || result.ready);
    assign in_ready = (pend_reg == '0) ||
                      ((pend_reg == wmlf_pkg::PEND_W'(1)) && issue);
    assign accept   = pixel.valid && in_ready;

    assign pixel.ready           = in_ready;
    assign result.valid          = out_valid_reg;
    assign result.smoothed_label = out_label_reg;
    assign result.line_done      = out_done_reg;

    always_comb
    begin
        win_next       = win_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        bypass_next    = bypass_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_label_next = out_label_reg;
        out_done_next  = out_done_reg;

        if (issue)
        begin
            out_valid_next = 1'b1;
            out_label_next = bypass_reg ? win_reg[0] : vote_label;
            out_done_next  = last_reg && (pend_reg == wmlf_pkg::PEND_W'(1));
            pend_next      = pend_reg - wmlf_pkg::PEND_W'(1);
            // Trailing results of a line see the last label repeated past the end.
            if (pend_reg > wmlf_pkg::PEND_W'(1))
            begin
                for (int i = MAX_TAPS - 1; i > 0; i--)
                begin
                    win_next[i] = win_reg[i - 1];
                end
                win_next[0] = win_reg[0];
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (short_line || (pos_reg != '0))
            begin
                for (int i = MAX_TAPS - 1; i > 0; i--)
                begin
                    win_next[i] = win_reg[i - 1];
                end
                win_next[0] = pixel.pixel_label;
            end
            else
            begin
                for (int i = 0; i < MAX_TAPS; i++)
                begin
                    win_next[i] = pixel.pixel_label;
                end
            end

            if (short_line)
            begin
                bypass_next = 1'b1;
                pend_next   = wmlf_pkg::PEND_W'(1);
                last_next   = (line_length_reg < wmlf_pkg::LINE_W'(2)) || line_end;
                pos_next    = last_next ? '0 : pos_reg + wmlf_pkg::LINE_W'(1);
            end
            else
            begin
                bypass_next = 1'b0;
                last_next   = line_end;
                pend_next   = ((pos_reg >= wmlf_pkg::LINE_W'(half)) ?
                               wmlf_pkg::PEND_W'(1) : '0) +
                              (line_end ? wmlf_pkg::PEND_W'(half) : '0);
                pos_next    = line_end ? '0 : pos_reg + wmlf_pkg::LINE_W'(1);
            end
        end

        if (restart)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pend_reg      <= '0;
            bypass_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            bypass_reg    <= bypass_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        out_label_reg <= out_label_next;
        out_done_reg  <= out_done_next;
    end

endmodule

FILE: hw/rtl/wmlf_vote.sv
module wmlf_vote #(
    parameter int MAX_TAPS = wmlf_pkg::MAX_TAPS_DEF
) (
    input  logic [wmlf_pkg::LABEL_W-1:0] win [MAX_TAPS],
    input  wmlf_pkg::vote_cfg_t          cfg,
    output logic [wmlf_pkg::LABEL_W-1:0] label
);

    localparam int IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SUM_W       = wmlf_pkg::COEF_W + $clog2(MAX_TAPS + 1);
    localparam int TREE_LEVELS = $clog2(MAX_TAPS);
    localparam int TREE_N      = 1 << TREE_LEVELS;

    logic [wmlf_pkg::COEF_W-1:0] coef [MAX_TAPS];
    logic [SUM_W-1:0]            sum [MAX_TAPS];
    logic [SUM_W-1:0]            acc [TREE_N];
    logic [MAX_TAPS-1:0]         active;
    logic [MAX_TAPS-1:0]         elig;
    logic [MAX_TAPS-1:0]         winner;
    logic [wmlf_pkg::LABEL_W-1:0] win_label;
    logic [IDX_W-1:0]            half_idx;

    always_comb
    begin
        for (int t = 0; t < MAX_TAPS; t++)
        begin
            if (t < wmlf_pkg::COEF_PACKS * 4)
            begin
                coef[t] = cfg.coef[(t >> 2) & 3][(t & 3) * wmlf_pkg::COEF_SLOT_W +:
                                                  wmlf_pkg::COEF_W];
            end
            else
            begin
                coef[t] = '0;
            end
            active[t] = (t < int'(cfg.taps));
        end

        for (int j = 0; j < MAX_TAPS; j++)
        begin
            for (int i = 0; i < TREE_N; i++)
            begin
                acc[i] = '0;
            end
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                if (active[i] && (win[i] == win[j]))
                begin
                    acc[i] = SUM_W'(coef[i]);
                end
            end
            for (int l = 0; l < TREE_LEVELS; l++)
            begin
                for (int i = 0; i < (TREE_N >> (l + 1)); i++)
                begin
                    acc[i << (l + 1)] = acc[i << (l + 1)] + acc[(i << (l + 1)) + (1 << l)];
                end
            end
            sum[j]  = acc[0];
            elig[j] = active[j] && (int'(win[j]) < wmlf_pkg::LABELS) && (sum[j] != '0);
        end

        for (int j = 0; j < MAX_TAPS; j++)
        begin
            winner[j] = elig[j];
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                if (elig[k] && !((sum[j] > sum[k]) ||
                                 ((sum[j] == sum[k]) && (win[j] <= win[k]))))
                begin
                    winner[j] = 1'b0;
                end
            end
        end

        win_label = '0;
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            win_label = win_label | (winner[j] ? win[j] : '0);
        end

        half_idx = IDX_W'(cfg.taps >> 1);
        label = (|winner) ? win_label : win[half_idx];
    end

endmodule

FILE: hw/rtl/wmlf_checker.sv
`include "assert_macros.svh"

module wmlf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [wmlf_pkg::LABEL_W-1:0] out_label,
    input logic                         out_done
);

    // A result that is not taken stays offered with the same contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_label) && $stable(out_done))

    // Without a new transaction the input side never closes again.
    `ASSERT_NEXT(a_ready_keeps, clk, rst_n, in_ready && !in_valid, in_ready)

    // The input only stalls while results are still being produced.
    `ASSERT_NEXT(a_stall_has_result, clk, rst_n, !in_ready, out_valid)

endmodule

bind weighted_mode_label_filter wmlf_checker u_wmlf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_label (result.smoothed_label),
    .out_done  (result.line_done)
);
